// File: sv/assert_macros.svh
// Assertion helpers shared by the input register and parser of the deframer.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the given clock and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define EDD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("Deframer assertion failed.");

// Checks that a signal keeps its value in the cycle after a condition holds.
`define EDD_ASSERT_STABLE(name, clk, rstn, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("Deframer hold check failed.");

`endif

// File: sv/edd_pkg.sv
// ----------------------------------------------------------------------------
// Event datagram deframer package
// Transfer types and result codes shared by the deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } edd_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] event_no;
    logic [31:0] game_id;
    logic [7:0]  player;
    logic [31:0] x_or_width;
    logic [31:0] y_or_height;
    logic [8:0]  player_count;
    logic [2:0]  error_code;
  } edd_out_t;

  localparam logic [2:0] KIND_NEW_GAME   = 3'd0;
  localparam logic [2:0] KIND_PIXEL      = 3'd1;
  localparam logic [2:0] KIND_ELIMINATED = 3'd2;
  localparam logic [2:0] KIND_GAME_OVER  = 3'd3;
  localparam logic [2:0] KIND_ERROR      = 3'd4;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_NAME    = 3'd1;
  localparam logic [2:0] ERR_FEW_PLAYERS = 3'd2;
  localparam logic [2:0] ERR_BOUNDS      = 3'd3;
  localparam logic [2:0] ERR_BAD_PLAYER  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

endpackage

`default_nettype wire

// File: sv/edd_in_reg.sv
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edd_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  stall_o,
  input  wire edd_pkg::edd_in_t data_i,
  input  wire logic             take_i,
  output logic                  valid_o,
  output edd_pkg::edd_in_t      data_o
);

  logic             valid_q;
  edd_pkg::edd_in_t data_q;
  logic             load;

  assign load    = !valid_q || take_i;
  assign stall_o = !load;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      data_q <= data_i;
    end
  end

  `EDD_ASSERT(a_held_valid, clk_i, rst_ni, valid_q && !take_i |=> valid_q)
  `EDD_ASSERT_STABLE(a_held_data, clk_i, rst_ni, valid_q && !take_i, data_q)

endmodule

`default_nettype wire

// File: sv/edd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Decodes one datagram byte per cycle while bytes are taken, and updates the game state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edd_parser #(
  parameter int unsigned MaxNameLen = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire edd_pkg::edd_in_t byte_i,
  output logic                  res_valid_o,
  output edd_pkg::edd_out_t     res_o
);

  localparam int unsigned NameLenW = $clog2(MaxNameLen + 1);
  localparam logic [NameLenW-1:0] NameLenMax = NameLenW'(MaxNameLen);

  localparam logic [7:0]  RT_NEW_GAME   = 8'd0;
  localparam logic [7:0]  RT_PIXEL      = 8'd1;
  localparam logic [7:0]  RT_ELIMINATED = 8'd2;
  localparam logic [7:0]  RT_GAME_OVER  = 8'd3;
  localparam logic [7:0]  NameCharMin   = 8'd33;
  localparam logic [7:0]  NameCharMax   = 8'd126;
  localparam logic [31:0] RecOverhead   = 32'd5;
  localparam logic [31:0] NewGameMinPay = 32'd8;
  localparam logic [31:0] PixelMinPay   = 32'd9;
  localparam logic [8:0]  PlayerSat     = 9'd256;
  localparam logic [8:0]  MinPlayers    = 9'd2;
  localparam logic [1:0]  FieldLast     = 2'd3;

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_EVNO = 6'b000100,
    PH_TYPE = 6'b001000,
    PH_PAY  = 6'b010000,
    PH_CRC  = 6'b100000
  } edd_phase_e;

  edd_phase_e          phase_q, phase_d;
  logic [31:0]         cnt_q, cnt_d;
  logic [31:0]         plen_q, plen_d;
  logic [23:0]         acc_q, acc_d;
  logic [31:0]         header_q, header_d;
  logic                in_game_q, in_game_d;
  logic [31:0]         active_q, active_d;
  logic [31:0]         bw_q, bw_d;
  logic [31:0]         bh_q, bh_d;
  logic [31:0]         exp_q, exp_d;
  logic [8:0]          known_q, known_d;
  logic [7:0]          rtype_q, rtype_d;
  logic [7:0]          hplayer_q, hplayer_d;
  logic [31:0]         hx_q, hx_d;
  logic [31:0]         hy_q, hy_d;
  logic [NameLenW-1:0] nlen_q, nlen_d;
  logic [8:0]          ntotal_q, ntotal_d;
  logic                nerr_q, nerr_d;
  logic                halted_q, halted_d;

  logic [7:0]          b;
  logic [31:0]         word;
  logic [31:0]         cnt_inc;
  logic                res_valid;
  edd_pkg::edd_out_t   res;

  assign b       = byte_i.data_byte;
  assign word    = {acc_q, b};
  assign cnt_inc = cnt_q + 32'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    plen_d    = plen_q;
    acc_d     = acc_q;
    header_d  = header_q;
    in_game_d = in_game_q;
    active_d  = active_q;
    bw_d      = bw_q;
    bh_d      = bh_q;
    exp_d     = exp_q;
    known_d   = known_q;
    rtype_d   = rtype_q;
    hplayer_d = hplayer_q;
    hx_d      = hx_q;
    hy_d      = hy_q;
    nlen_d    = nlen_q;
    ntotal_d  = ntotal_q;
    nerr_d    = nerr_q;
    halted_d  = halted_q;
    res_valid = 1'b0;
    res       = '0;
    res.event_no = exp_q;
    res.game_id  = header_q;

    if (take_i) begin
      if (!halted_q) begin
        unique case (phase_q)
          PH_HDR: begin
            header_d = {header_q[23:0], b};
            if (cnt_q[1:0] == FieldLast) begin
              cnt_d   = '0;
              acc_d   = '0;
              phase_d = PH_LEN;
              if (in_game_q && (header_d != active_q)) begin
                halted_d = 1'b1;
              end
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PH_LEN: begin
            if (cnt_q[1:0] == FieldLast) begin
              cnt_d  = '0;
              acc_d  = '0;
              plen_d = word - RecOverhead;
              if (word < RecOverhead) begin
                halted_d       = 1'b1;
                res_valid      = 1'b1;
                res.kind       = edd_pkg::KIND_ERROR;
                res.error_code = edd_pkg::ERR_TRUNCATED;
              end else begin
                phase_d = PH_EVNO;
              end
            end else begin
              acc_d = word[23:0];
              cnt_d = cnt_inc;
            end
          end
          PH_EVNO: begin
            if (cnt_q[1:0] == FieldLast) begin
              cnt_d = '0;
              acc_d = '0;
              if (word != exp_q) begin
                halted_d = 1'b1;
              end else begin
                phase_d = PH_TYPE;
              end
            end else begin
              acc_d = word[23:0];
              cnt_d = cnt_inc;
            end
          end
          PH_TYPE: begin
            rtype_d   = b;
            hplayer_d = '0;
            hx_d      = '0;
            hy_d      = '0;
            nlen_d    = '0;
            ntotal_d  = '0;
            nerr_d    = 1'b0;
            cnt_d     = '0;
            phase_d   = (plen_q == '0) ? PH_CRC : PH_PAY;
          end
          PH_PAY: begin
            if ((rtype_q == RT_PIXEL) || (rtype_q == RT_ELIMINATED)) begin
              if (cnt_q == 32'd0) begin
                hplayer_d = b;
              end else if (cnt_q <= 32'd4) begin
                hx_d = {hx_q[23:0], b};
              end else if (cnt_q <= 32'd8) begin
                hy_d = {hy_q[23:0], b};
              end
            end else if (rtype_q == RT_NEW_GAME) begin
              if (cnt_q < 32'd4) begin
                hx_d = {hx_q[23:0], b};
              end else if (cnt_q < 32'd8) begin
                hy_d = {hy_q[23:0], b};
              end else if (b == 8'd0) begin
                if (ntotal_q < PlayerSat) begin
                  ntotal_d = ntotal_q + 9'd1;
                end
                nlen_d = '0;
              end else begin
                if ((b < NameCharMin) || (b > NameCharMax)) begin
                  nerr_d = 1'b1;
                end
                if (nlen_q >= NameLenMax) begin
                  nerr_d = 1'b1;
                end else begin
                  nlen_d = nlen_q + NameLenW'(1);
                end
              end
            end
            if (cnt_inc == plen_q) begin
              cnt_d   = '0;
              phase_d = PH_CRC;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PH_CRC: begin
            if (cnt_q[1:0] == FieldLast) begin
              cnt_d   = '0;
              acc_d   = '0;
              phase_d = PH_LEN;
              unique case (rtype_q)
                RT_NEW_GAME: begin
                  res_valid = 1'b1;
                  if (in_game_q) begin
                    res_valid = 1'b0;
                    exp_d     = exp_q + 32'd1;
                  end else if (plen_q < NewGameMinPay) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_TRUNCATED;
                  end else if (nerr_q || (nlen_q != '0)) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_BAD_NAME;
                  end else if (ntotal_q < MinPlayers) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_FEW_PLAYERS;
                  end else begin
                    in_game_d        = 1'b1;
                    active_d         = header_q;
                    bw_d             = hx_q;
                    bh_d             = hy_q;
                    known_d          = ntotal_q;
                    exp_d            = exp_q + 32'd1;
                    res.kind         = edd_pkg::KIND_NEW_GAME;
                    res.x_or_width   = hx_q;
                    res.y_or_height  = hy_q;
                    res.player_count = ntotal_q;
                  end
                end
                RT_PIXEL: begin
                  res_valid = 1'b1;
                  if (plen_q < PixelMinPay) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_TRUNCATED;
                  end else if ((hx_q >= bw_q) || (hy_q >= bh_q)) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_BOUNDS;
                  end else if ({1'b0, hplayer_q} >= known_q) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_BAD_PLAYER;
                  end else begin
                    exp_d           = exp_q + 32'd1;
                    res.kind        = edd_pkg::KIND_PIXEL;
                    res.player      = hplayer_q;
                    res.x_or_width  = hx_q;
                    res.y_or_height = hy_q;
                  end
                end
                RT_ELIMINATED: begin
                  res_valid = 1'b1;
                  if (plen_q == '0) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_TRUNCATED;
                  end else if ({1'b0, hplayer_q} >= known_q) begin
                    halted_d       = 1'b1;
                    res.kind       = edd_pkg::KIND_ERROR;
                    res.error_code = edd_pkg::ERR_BAD_PLAYER;
                  end else begin
                    exp_d      = exp_q + 32'd1;
                    res.kind   = edd_pkg::KIND_ELIMINATED;
                    res.player = hplayer_q;
                  end
                end
                RT_GAME_OVER: begin
                  res_valid = 1'b1;
                  res.kind  = edd_pkg::KIND_GAME_OVER;
                  exp_d     = '0;
                  in_game_d = 1'b0;
                end
                default: begin
                end
              endcase
            end else begin
              cnt_d = cnt_inc;
            end
          end
          default: begin
          end
        endcase
      end

      if (byte_i.last_byte) begin
        if (!halted_d && !res_valid && !((phase_d == PH_LEN) && (cnt_d == '0))) begin
          res_valid      = 1'b1;
          res            = '0;
          res.kind       = edd_pkg::KIND_ERROR;
          res.event_no   = exp_q;
          res.game_id    = header_d;
          res.error_code = edd_pkg::ERR_TRUNCATED;
        end
        phase_d  = PH_HDR;
        cnt_d    = '0;
        acc_d    = '0;
        header_d = '0;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      cnt_q     <= '0;
      plen_q    <= '0;
      acc_q     <= '0;
      header_q  <= '0;
      in_game_q <= 1'b0;
      active_q  <= '0;
      bw_q      <= '0;
      bh_q      <= '0;
      exp_q     <= '0;
      known_q   <= '0;
      rtype_q   <= '0;
      hplayer_q <= '0;
      hx_q      <= '0;
      hy_q      <= '0;
      nlen_q    <= '0;
      ntotal_q  <= '0;
      nerr_q    <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      plen_q    <= plen_d;
      acc_q     <= acc_d;
      header_q  <= header_d;
      in_game_q <= in_game_d;
      active_q  <= active_d;
      bw_q      <= bw_d;
      bh_q      <= bh_d;
      exp_q     <= exp_d;
      known_q   <= known_d;
      rtype_q   <= rtype_d;
      hplayer_q <= hplayer_d;
      hx_q      <= hx_d;
      hy_q      <= hy_d;
      nlen_q    <= nlen_d;
      ntotal_q  <= ntotal_d;
      nerr_q    <= nerr_d;
      halted_q  <= halted_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

  `EDD_ASSERT(a_hdr_quiet, clk_i, rst_ni,
              take_i && !byte_i.last_byte && (phase_q == PH_HDR) |-> !res_valid)
  `EDD_ASSERT(a_code_kind, clk_i, rst_ni,
              res_valid && (res.kind != edd_pkg::KIND_ERROR) |->
              (res.error_code == edd_pkg::ERR_NONE))
  `EDD_ASSERT(a_game_players, clk_i, rst_ni, in_game_q |-> (known_q >= MinPlayers))

endmodule

`default_nettype wire

// File: sv/edd_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic              res_valid_i,
  input  wire edd_pkg::edd_out_t res_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output edd_pkg::edd_out_t      data_o
);

  logic              valid_q;
  edd_pkg::edd_out_t data_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/event_datagram_deframer_top.sv
// ----------------------------------------------------------------------------
// Event datagram deframer
// Byte-serial decoder of game-event datagrams with at most one result per record.
// ----------------------------------------------------------------------------
// The input channel carries one datagram byte per transfer, with last_byte set
// on the final byte. The block checks the game id, walks the records and
// produces at most one result transfer per input byte on the output channel.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low.
// An input byte is registered in the input register when it is transferred and
// is decoded by combinational logic once the result register can load; the
// result is then registered there. The block takes one byte per cycle while the
// receiver does not stall; the decode path is combinational between the two.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; input stall rises only once both are full.
// Reset clears the game state, the expected event number and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_datagram_deframer_top #(
  parameter int unsigned MaxNameLen = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire edd_pkg::edd_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output edd_pkg::edd_out_t     out_data_o
);

  logic              byte_valid;
  edd_pkg::edd_in_t  byte_data;
  logic              take;
  logic              out_ready;
  logic              res_valid;
  edd_pkg::edd_out_t res;

  assign take = byte_valid && out_ready;

  edd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .take_i  (take),
    .valid_o (byte_valid),
    .data_o  (byte_data)
  );

  edd_parser #(
    .MaxNameLen (MaxNameLen)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (byte_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  edd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/event_datagram_deframer_top_test.sv
// ----------------------------------------------------------------------------
// Event datagram deframer testbench
// Sends game-event datagrams byte by byte and checks every decoded event.
// ----------------------------------------------------------------------------
// Most datagrams are well formed and follow the running game: a new game, then
// pixels, eliminations, unknown records and a game over, with random board
// sizes, names and checksums. The rest carry bad names, foreign game ids,
// wrong event numbers, short payloads, short record lengths, cut-off endings
// and plain noise. A scoreboard decodes each accepted byte itself and compares
// every result transfer, field by field, with the oldest event it expects.
// Both sides pause in random bursts, and once the receiver holds off long
// enough for the deframer to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_datagram_deframer_top_test;

  localparam int unsigned MAX_NAME = 20;
  localparam int unsigned ITEMS = 1100;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 10;

  localparam logic [7:0] REC_NEW_GAME   = 8'd0;
  localparam logic [7:0] REC_PIXEL      = 8'd1;
  localparam logic [7:0] REC_ELIMINATED = 8'd2;
  localparam logic [7:0] REC_GAME_OVER  = 8'd3;
  localparam logic [7:0] REC_FIRST_UNKNOWN = 8'd4;

  typedef enum logic [2:0] {
    PH_HEADER, PH_LENGTH, PH_EVENT, PH_TYPE, PH_PAYLOAD, PH_CHECKSUM
  } parse_phase_e;

  class deframe_scoreboard;
    bit                 in_game;
    logic [31:0]        active_id, board_w, board_h, next_event;
    logic [8:0]         known_players;
    parse_phase_e       phase;
    logic [31:0]        count, rec_len, acc, hdr_id, rec_event;
    logic [7:0]         rec_type, held_player;
    logic [31:0]        held_x, held_y;
    logic [4:0]         name_len;
    logic [8:0]         name_count;
    bit                 name_bad, halted, produced;
    edd_pkg::edd_out_t  pending[$];
    int unsigned        failures;

    function new();
      in_game = 0; active_id = '0; board_w = '0; board_h = '0; next_event = '0;
      known_players = '0; phase = PH_HEADER; count = '0; rec_len = '0; acc = '0;
      hdr_id = '0; rec_event = '0; rec_type = '0; held_player = '0; held_x = '0;
      held_y = '0; name_len = '0; name_count = '0; name_bad = 0; halted = 0;
      failures = 0;
    endfunction

    function void post_event(logic [2:0] kind, logic [7:0] player, logic [31:0] x,
                             logic [31:0] y, logic [8:0] players, logic [2:0] code);
      edd_pkg::edd_out_t ev;
      ev.kind = kind;
      ev.event_no = next_event;
      ev.game_id = hdr_id;
      ev.player = player;
      ev.x_or_width = x;
      ev.y_or_height = y;
      ev.player_count = players;
      ev.error_code = code;
      pending.insert(pending.size(), ev);
      produced = 1;
    endfunction

    function void raise_error(logic [2:0] code);
      halted = 1;
      post_event(edd_pkg::KIND_ERROR, '0, '0, '0, '0, code);
    endfunction

    function void take_payload(logic [7:0] b);
      if (rec_type == REC_PIXEL || rec_type == REC_ELIMINATED) begin
        if (count == 0) held_player = b;
        else if (count <= 4) held_x = {held_x[23:0], b};
        else if (count <= 8) held_y = {held_y[23:0], b};
      end else if (rec_type == REC_NEW_GAME) begin
        if (count < 4) held_x = {held_x[23:0], b};
        else if (count < 8) held_y = {held_y[23:0], b};
        else if (b == 8'd0) begin
          if (name_count < 9'd256) name_count++;
          name_len = '0;
        end else begin
          if (b < 8'd33 || b > 8'd126) name_bad = 1;
          if (name_len >= MAX_NAME) name_bad = 1;
          else name_len++;
        end
      end
    endfunction

    function void close_record();
      logic [31:0] plen;
      plen = rec_len - 32'd5;
      case (rec_type)
        REC_NEW_GAME: begin
          if (in_game) next_event++;
          else if (plen < 8) raise_error(edd_pkg::ERR_TRUNCATED);
          else if (name_bad || name_len != 0) raise_error(edd_pkg::ERR_BAD_NAME);
          else if (name_count < 2) raise_error(edd_pkg::ERR_FEW_PLAYERS);
          else begin
            in_game = 1;
            active_id = hdr_id;
            board_w = held_x;
            board_h = held_y;
            known_players = name_count;
            post_event(edd_pkg::KIND_NEW_GAME, '0, held_x, held_y, name_count,
                       edd_pkg::ERR_NONE);
            next_event++;
          end
        end
        REC_PIXEL: begin
          if (plen < 9) raise_error(edd_pkg::ERR_TRUNCATED);
          else if (held_x >= board_w || held_y >= board_h) raise_error(edd_pkg::ERR_BOUNDS);
          else if ({1'b0, held_player} >= known_players) begin
            raise_error(edd_pkg::ERR_BAD_PLAYER);
          end else begin
            post_event(edd_pkg::KIND_PIXEL, held_player, held_x, held_y, '0,
                       edd_pkg::ERR_NONE);
            next_event++;
          end
        end
        REC_ELIMINATED: begin
          if (plen < 1) raise_error(edd_pkg::ERR_TRUNCATED);
          else if ({1'b0, held_player} >= known_players) begin
            raise_error(edd_pkg::ERR_BAD_PLAYER);
          end else begin
            post_event(edd_pkg::KIND_ELIMINATED, held_player, '0, '0, '0,
                       edd_pkg::ERR_NONE);
            next_event++;
          end
        end
        REC_GAME_OVER: begin
          post_event(edd_pkg::KIND_GAME_OVER, '0, '0, '0, '0, edd_pkg::ERR_NONE);
          next_event = '0;
          in_game = 0;
        end
        default: ;
      endcase
    endfunction

    function void decode_byte(logic [7:0] b);
      case (phase)
        PH_HEADER: begin
          hdr_id = {hdr_id[23:0], b};
          count++;
          if (count == 4) begin
            count = '0;
            acc = '0;
            phase = PH_LENGTH;
            if (in_game && hdr_id != active_id) halted = 1;
          end
        end
        PH_LENGTH: begin
          acc = {acc[23:0], b};
          count++;
          if (count == 4) begin
            rec_len = acc;
            count = '0;
            acc = '0;
            if (rec_len < 5) raise_error(edd_pkg::ERR_TRUNCATED);
            else phase = PH_EVENT;
          end
        end
        PH_EVENT: begin
          acc = {acc[23:0], b};
          count++;
          if (count == 4) begin
            rec_event = acc;
            count = '0;
            acc = '0;
            if (rec_event != next_event) halted = 1;
            else phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          rec_type = b;
          held_player = '0; held_x = '0; held_y = '0;
          name_len = '0; name_count = '0; name_bad = 0;
          count = '0;
          phase = (rec_len == 5) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          take_payload(b);
          count++;
          if (count == rec_len - 32'd5) begin
            count = '0;
            phase = PH_CHECKSUM;
          end
        end
        default: begin
          count++;
          if (count >= 4) begin
            count = '0;
            acc = '0;
            phase = PH_LENGTH;
            close_record();
          end
        end
      endcase
    endfunction

    function void note_byte(edd_pkg::edd_in_t item);
      produced = 0;
      if (!halted) decode_byte(item.data_byte);
      if (item.last_byte) begin
        if (!halted && !produced && !(phase == PH_LENGTH && count == 0)) begin
          raise_error(edd_pkg::ERR_TRUNCATED);
        end
        phase = PH_HEADER;
        count = '0;
        acc = '0;
        hdr_id = '0;
        halted = 0;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(edd_pkg::edd_out_t got);
      edd_pkg::edd_out_t want;
      if (pending.size() == 0) begin
        $error("Result transfer arrived with no event outstanding.");
        failures++;
        return;
      end
      want = pending.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("event_no", want.event_no, got.event_no);
      compare_field("game_id", want.game_id, got.game_id);
      compare_field("player", 32'(want.player), 32'(got.player));
      compare_field("x_or_width", want.x_or_width, got.x_or_width);
      compare_field("y_or_height", want.y_or_height, got.y_or_height);
      compare_field("player_count", 32'(want.player_count), 32'(got.player_count));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  edd_pkg::edd_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  edd_pkg::edd_out_t out_data;

  deframe_scoreboard sb;
  logic [7:0]  frame[$];
  logic [7:0]  body[$];
  int unsigned sent;
  bit          quiet, tx_idle, hold_off_req, hold_off_done, hold_off_active;

  bit          g_in;
  logic [31:0] g_ev, g_w, g_h;
  logic [8:0]  g_players;

  event_datagram_deframer_top #(.MaxNameLen(MAX_NAME)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("event_datagram_deframer_top_test: FAIL");
    $finish;
  end

  function automatic void frame_add(logic [7:0] b);
    frame.insert(frame.size(), b);
  endfunction

  function automatic void body_add(logic [7:0] b);
    body.insert(body.size(), b);
  endfunction

  function automatic void put_word(logic [31:0] w);
    frame_add(w[31:24]);
    frame_add(w[23:16]);
    frame_add(w[15:8]);
    frame_add(w[7:0]);
  endfunction

  function automatic void body_word(logic [31:0] w);
    body_add(w[31:24]);
    body_add(w[23:16]);
    body_add(w[15:8]);
    body_add(w[7:0]);
  endfunction

  function automatic void put_record(logic [31:0] len, logic [31:0] ev, logic [7:0] rtype);
    put_word(len);
    put_word(ev);
    frame_add(rtype);
    foreach (body[i]) frame_add(body[i]);
    put_word($urandom);
    body.delete();
  endfunction

  function automatic logic [31:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  function automatic void add_name(int unsigned len, bit bad_char, bit terminate);
    logic [7:0] c;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) c = $urandom_range(0, 1) ? 8'd33 : 8'd126;
      else c = 8'($urandom_range(33, 126));
      if (bad_char && i == len - 1) begin
        c = $urandom_range(0, 1) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(127, 255));
      end
      body_add(c);
    end
    if (terminate) body_add(8'd0);
  endfunction

  function automatic bit add_random_record();
    logic [31:0] ev, x, y;
    logic [7:0]  player;
    int unsigned roll, mode, cnt, len, keep;
    bit          ok;
    body.delete();
    ev = g_ev;
    if ($urandom_range(0, 24) == 0) ev = g_ev + $urandom_range(1, 3);
    roll = $urandom_range(0, 99);
    if (!g_in && roll < 75) roll = 0;
    if (roll < 15) begin
      x = pick_extent();
      y = pick_extent();
      body_word(x);
      body_word(y);
      mode = $urandom_range(0, 19);
      if (mode == 17) cnt = $urandom_range(0, 1);
      else if ($urandom_range(0, 11) == 0) cnt = $urandom_range(250, 260);
      else cnt = $urandom_range(2, 5);
      for (int unsigned n = 0; n < cnt; n++) begin
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = MAX_NAME;
          default: len = $urandom_range(1, 6);
        endcase
        if (cnt > 5) len = 0;
        if ((mode == 14 || mode == 16) && n == cnt - 1 && len == 0) len = 1;
        if (mode == 15 && n == 0) len = MAX_NAME + 1;
        add_name(len, mode == 14 && n == cnt - 1, !(mode == 16 && n == cnt - 1));
      end
      if (mode == 18) begin
        keep = $urandom_range(0, 7);
        while (body.size() > keep) void'(body.pop_back());
      end
      put_record(5 + body.size(), ev, REC_NEW_GAME);
      if (ev != g_ev) return 0;
      if (g_in) begin
        g_ev++;
        return 1;
      end
      if (mode >= 14 && mode <= 18) return 0;
      g_in = 1;
      g_w = x;
      g_h = y;
      g_players = (cnt > 256) ? 9'd256 : 9'(cnt);
      g_ev++;
      return 1;
    end else if (roll < 75) begin
      mode = $urandom_range(0, 9);
      player = (g_players != 0) ? 8'($urandom_range(0, g_players - 1)) : 8'd0;
      x = (g_w != 0) ? $urandom % g_w : 32'd0;
      y = (g_h != 0) ? $urandom % g_h : 32'd0;
      if (roll < 60) begin
        if (mode == 0) x = $urandom_range(0, 1) ? g_w : 32'hFFFF_FFFF;
        if (mode == 1) y = $urandom_range(0, 1) ? g_h : 32'hFFFF_FFFF;
        if (mode == 2) player = (g_players < 256) ? g_players[7:0] : 8'hFF;
        body_add(player);
        body_word(x);
        body_word(y);
        if (mode == 3) begin
          keep = $urandom_range(0, 8);
          while (body.size() > keep) void'(body.pop_back());
        end
        if (mode == 4) repeat ($urandom_range(1, 3)) body_add(8'($urandom));
        ok = body.size() >= 9 && x < g_w && y < g_h && {1'b0, player} < g_players;
        put_record(5 + body.size(), ev, REC_PIXEL);
      end else begin
        if (mode == 0) player = (g_players < 256) ? g_players[7:0] : 8'hFF;
        if (mode != 1) body_add(player);
        if (mode == 2) repeat ($urandom_range(1, 3)) body_add(8'($urandom));
        ok = body.size() >= 1 && {1'b0, player} < g_players;
        put_record(5 + body.size(), ev, REC_ELIMINATED);
      end
      if (ev != g_ev || !ok) return 0;
      g_ev++;
      return 1;
    end else if (roll < 85) begin
      repeat ($urandom_range(0, 3)) body_add(8'($urandom));
      put_record(5 + body.size(), ev, REC_GAME_OVER);
      if (ev != g_ev) return 0;
      g_ev = '0;
      g_in = 0;
      return 1;
    end else if (roll < 95) begin
      repeat ($urandom_range(0, 6)) body_add(8'($urandom));
      put_record(5 + body.size(), ev, 8'($urandom_range(REC_FIRST_UNKNOWN, 255)));
      return ev == g_ev;
    end
    put_word($urandom_range(0, 4));
    put_word(ev);
    return 0;
  endfunction

  function automatic void build_random_datagram();
    int unsigned roll, nrec, cut;
    logic [31:0] id;
    bit          going;
    frame.delete();
    g_in = sb.in_game;
    g_ev = sb.next_event;
    g_w = sb.board_w;
    g_h = sb.board_h;
    g_players = sb.known_players;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 20)) frame_add(8'($urandom));
      return;
    end
    if (g_in) id = (roll < 12) ? $urandom : sb.active_id;
    else id = ($urandom_range(0, 3) == 0) ? sb.active_id : $urandom;
    put_word(id);
    nrec = (roll < 15) ? 0 : $urandom_range(1, 4);
    going = 1;
    for (int unsigned i = 0; i < nrec && going; i++) going = add_random_record();
    if (roll >= 90) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    edd_pkg::edd_in_t item;
    if (!quiet && tx_idle && !hold_off_active && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 17)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    item.data_byte = b;
    item.last_byte = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(item);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  initial begin : receiver
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold = HOLD_OFF_CYCLES;
        hold_off_done = 1;
        hold_off_active = 1;
      end else if (hold == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 17);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold_off_active = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  initial begin : stimulus
    sb = new();
    sent = 0;
    quiet = 0;
    tx_idle = 1;
    hold_off_req = 0;
    hold_off_done = 0;
    hold_off_active = 0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A lone byte cannot complete a header.
    frame.delete();
    frame_add(8'h00);
    send_frame();

    // Widest board, names at both ends of the printable range.
    frame.delete();
    put_word(32'hFFFF_FFFF);
    body_word(32'hFFFF_FFFF);
    body_word(32'd1);
    body_add(8'd33);
    body_add(8'd0);
    body_add(8'd126);
    body_add(8'd0);
    put_record(5 + body.size(), 32'd0, REC_NEW_GAME);
    send_frame();

    frame.delete();
    put_word(32'hFFFF_FFFF);
    body_add(8'd1);
    body_word(32'hFFFF_FFFE);
    body_word(32'd0);
    put_record(32'd14, 32'd1, REC_PIXEL);
    body_add(8'd0);
    put_record(32'd6, 32'd2, REC_ELIMINATED);
    put_record(32'd5, 32'd3, 8'hFF);
    put_record(32'd5, 32'd3, REC_GAME_OVER);
    send_frame();

    // With no game running the old board still bounds pixels.
    frame.delete();
    put_word(32'd0);
    body_add(8'd0);
    body_word(32'd0);
    body_word(32'd0);
    put_record(32'd14, 32'd0, REC_PIXEL);
    put_word(32'd4);
    send_frame();

    while (sent < ITEMS) begin
      if (sent > 300) hold_off_req = 1;
      if (sent > ITEMS * 4 / 5) quiet = 1;
      tx_idle = $urandom_range(0, 3) != 0;
      build_random_datagram();
      send_frame();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("event_datagram_deframer_top_test: PASS");
    end else begin
      $display("event_datagram_deframer_top_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
